### rtl/gradient_magnitude_stream_defines.svh
// ----------------------------------------------------------------------------
// gradient_magnitude_stream_defines
// Assertion macros shared by the gradient magnitude block.
// ----------------------------------------------------------------------------
`ifndef GRADIENT_MAGNITUDE_STREAM_DEFINES_SVH
`define GRADIENT_MAGNITUDE_STREAM_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define GMS_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("gradient_magnitude_stream: same-cycle check failed");

// Check that a condition implies another in the following cycle.
`define GMS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("gradient_magnitude_stream: next-cycle check failed");

`endif

### rtl/gms_pkg.sv
// ----------------------------------------------------------------------------
// gms_pkg
// Types and constants of the gradient magnitude block.
// ----------------------------------------------------------------------------
package gms_pkg;

   localparam int PixelBits    = 8;
   localparam int MaxWidth     = 1024;
   localparam int MaxHeight    = 4096;
   localparam int ColBits      = $clog2(MaxWidth);
   localparam int RowBits      = $clog2(MaxHeight);
   localparam int WidthBits    = 11;
   localparam int HeightBits   = 13;
   localparam int CsrIndexBits = 2;
   localparam int CsrDataBits  = 13;
   localparam int DiffBits     = PixelBits + 1;
   localparam int RootBits     = 9;
   localparam int RemBits      = RootBits + 1;
   localparam int SumBits      = 2 * RootBits;
   localparam int StepBits     = $clog2(RootBits);

   localparam logic [CsrIndexBits-1:0] CSR_FRAME_WIDTH  = CsrIndexBits'(0);
   localparam logic [CsrIndexBits-1:0] CSR_FRAME_HEIGHT = CsrIndexBits'(1);

   localparam logic [WidthBits-1:0]  WidthReset  = WidthBits'(640);
   localparam logic [HeightBits-1:0] HeightReset = HeightBits'(480);
   localparam logic [WidthBits-1:0]  WidthMin    = WidthBits'(3);
   localparam logic [WidthBits-1:0]  WidthMax    = WidthBits'(MaxWidth);
   localparam logic [HeightBits-1:0] HeightMin   = HeightBits'(3);
   localparam logic [HeightBits-1:0] HeightMax   = HeightBits'(MaxHeight);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SQUARE,
      ST_ROOT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic capture;     // take the pixel, read both line buffers
      logic update;      // write lines, shift window, form differences
      logic root_start;  // square and sum, load the root unit
      logic root_step;   // one digit of the root
      logic publish;     // load the result register
   } cmd_type;

   typedef struct packed {
      logic emit;        // current pixel closes an interior window
      logic root_done;   // root unit is on its last digit
      logic rsp_free;    // result register can take a new beat
   } status_type;

endpackage

### rtl/gms_isqrt.sv
// ----------------------------------------------------------------------------
// gms_isqrt
// Digit-serial floor square root, one result bit per step.
// ----------------------------------------------------------------------------
module gms_isqrt (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic                         step,
   input  logic [gms_pkg::SumBits-1:0]  radicand,
   output logic [gms_pkg::RootBits-1:0] root,
   output logic                         done
);
   import gms_pkg::*;

   logic [SumBits-1:0]  radicand_ff;
   logic [RemBits-1:0]  rem_ff;
   logic [RootBits-1:0] root_ff;
   logic [StepBits-1:0] count_ff;
   logic [RemBits+1:0]  rem_shift;
   logic [RemBits+1:0]  trial;

   always_comb begin
      rem_shift = {rem_ff, radicand_ff[SumBits-1 -: 2]};
      trial     = {1'b0, root_ff, 2'b01};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (start) begin
         count_ff <= StepBits'(RootBits - 1);
      end else if (step) begin
         count_ff <= count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         radicand_ff <= radicand;
         rem_ff      <= '0;
         root_ff     <= '0;
      end else if (step) begin
         radicand_ff <= {radicand_ff[SumBits-3:0], 2'b00};
         if (rem_shift >= trial) begin
            rem_ff  <= RemBits'(rem_shift - trial);
            root_ff <= {root_ff[RootBits-2:0], 1'b1};
         end else begin
            rem_ff  <= rem_shift[RemBits-1:0];
            root_ff <= {root_ff[RootBits-2:0], 1'b0};
         end
      end
   end

   assign done = (count_ff == '0);
   assign root = root_ff;

endmodule

### rtl/gms_datapath.sv
// ----------------------------------------------------------------------------
// gms_datapath
// Line buffers, window, frame counters, differences and result register.
// ----------------------------------------------------------------------------
module gms_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  gms_pkg::cmd_type                 cmd,
   output gms_pkg::status_type              status,
   input  logic [gms_pkg::PixelBits-1:0]    req_pixel,
   input  logic                             csr_we,
   input  logic [gms_pkg::CsrIndexBits-1:0] csr_index,
   input  logic [gms_pkg::CsrDataBits-1:0]  csr_wdata,
   input  logic                             rsp_ready,
   output logic                             rsp_valid,
   output logic [gms_pkg::RowBits-1:0]      rsp_out_row,
   output logic [gms_pkg::ColBits-1:0]      rsp_out_col,
   output logic [gms_pkg::RootBits-1:0]     rsp_magnitude,
   output logic                             rsp_frame_last
);
   import gms_pkg::*;

   logic [WidthBits-1:0]  frame_width_ff;
   logic [HeightBits-1:0] frame_height_ff;
   logic [RowBits-1:0]    row_ff;
   logic [ColBits-1:0]    col_ff;
   logic [PixelBits-1:0]  pixel_ff;
   logic [PixelBits-1:0]  above2_ff;
   logic [PixelBits-1:0]  above1_ff;
   logic [PixelBits-1:0]  win_ff [4];
   logic [PixelBits-1:0]  older_mem [MaxWidth];
   logic [PixelBits-1:0]  newer_mem [MaxWidth];
   logic signed [DiffBits-1:0] dx_ff;
   logic signed [DiffBits-1:0] dy_ff;
   logic [RowBits-1:0]    meta_row_ff;
   logic [ColBits-1:0]    meta_col_ff;
   logic                  meta_last_ff;
   logic                  rsp_valid_ff;
   logic [RowBits-1:0]    rsp_row_ff;
   logic [ColBits-1:0]    rsp_col_ff;
   logic [RootBits-1:0]   rsp_mag_ff;
   logic                  rsp_last_ff;

   logic [WidthBits-1:0]  width_eff;
   logic [HeightBits-1:0] height_eff;
   logic [WidthBits-1:0]  width_last;
   logic [HeightBits-1:0] height_last;
   logic                  col_end;
   logic                  row_end;
   logic signed [2*DiffBits-1:0] dx_sq;
   logic signed [2*DiffBits-1:0] dy_sq;
   logic [SumBits-1:0]    sum_sq;
   logic [RootBits-1:0]   root;
   logic                  root_done;

   // Clamp the frame size to the supported range.
   always_comb begin
      if (frame_width_ff < WidthMin) begin
         width_eff = WidthMin;
      end else if (frame_width_ff > WidthMax) begin
         width_eff = WidthMax;
      end else begin
         width_eff = frame_width_ff;
      end
      if (frame_height_ff < HeightMin) begin
         height_eff = HeightMin;
      end else if (frame_height_ff > HeightMax) begin
         height_eff = HeightMax;
      end else begin
         height_eff = frame_height_ff;
      end
      width_last  = width_eff - 1'b1;
      height_last = height_eff - 1'b1;
      col_end     = (col_ff >= width_last[ColBits-1:0]);
      row_end     = (row_ff >= height_last[RowBits-1:0]);
   end

   always_comb begin
      dx_sq  = dx_ff * dx_ff;
      dy_sq  = dy_ff * dy_ff;
      sum_sq = SumBits'($unsigned(dx_sq)) + SumBits'($unsigned(dy_sq));
   end

   // Configuration and frame position.
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= WidthReset;
         frame_height_ff <= HeightReset;
         row_ff          <= '0;
         col_ff          <= '0;
      end else if (csr_we) begin
         if (csr_index == CSR_FRAME_WIDTH) begin
            frame_width_ff <= csr_wdata[WidthBits-1:0];
         end
         if (csr_index == CSR_FRAME_HEIGHT) begin
            frame_height_ff <= csr_wdata[HeightBits-1:0];
         end
         row_ff <= '0;
         col_ff <= '0;
      end else if (cmd.update) begin
         if (col_end) begin
            col_ff <= '0;
            row_ff <= row_end ? '0 : row_ff + 1'b1;
         end else begin
            col_ff <= col_ff + 1'b1;
         end
      end
   end

   // Line buffers: read at capture, write back the same column at update.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         above2_ff <= older_mem[col_ff];
         above1_ff <= newer_mem[col_ff];
      end
      if (cmd.update) begin
         older_mem[col_ff] <= above1_ff;
         newer_mem[col_ff] <= pixel_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            win_ff[i] <= '0;
         end
      end else if (cmd.update) begin
         win_ff[0] <= above2_ff;
         win_ff[1] <= above1_ff;
         win_ff[2] <= win_ff[1];
         win_ff[3] <= pixel_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         pixel_ff <= req_pixel;
      end
      if (cmd.update) begin
         dy_ff        <= $signed({1'b0, win_ff[0]}) - $signed({1'b0, win_ff[3]});
         dx_ff        <= $signed({1'b0, above1_ff}) - $signed({1'b0, win_ff[2]});
         meta_row_ff  <= row_ff - 1'b1;
         meta_col_ff  <= col_ff - 1'b1;
         meta_last_ff <= row_end && col_end;
      end
   end

   gms_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.root_start),
      .step     (cmd.root_step),
      .radicand (sum_sq),
      .root     (root),
      .done     (root_done)
   );

   // Result register: hold a beat until taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.publish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         rsp_row_ff  <= meta_row_ff;
         rsp_col_ff  <= meta_col_ff;
         rsp_mag_ff  <= root;
         rsp_last_ff <= meta_last_ff;
      end
   end

   always_comb begin
      status.emit      = (row_ff >= RowBits'(2)) && (col_ff >= ColBits'(2));
      status.root_done = root_done;
      status.rsp_free  = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_row    = rsp_row_ff;
   assign rsp_out_col    = rsp_col_ff;
   assign rsp_magnitude  = rsp_mag_ff;
   assign rsp_frame_last = rsp_last_ff;

endmodule

### rtl/gms_ctrl.sv
// ----------------------------------------------------------------------------
// gms_ctrl
// Sequencer for one pixel: read, update and, on emit, square, root, publish.
// ----------------------------------------------------------------------------
module gms_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output gms_pkg::cmd_type    cmd,
   input  gms_pkg::status_type status
);
   import gms_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            state_in = status.emit ? ST_SQUARE : ST_IDLE;
         end
         ST_SQUARE: begin
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            if (status.root_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (status.rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_LOAD: begin
            cmd.update = 1'b1;
         end
         ST_SQUARE: begin
            cmd.root_start = 1'b1;
         end
         ST_ROOT: begin
            cmd.root_step = 1'b1;
         end
         ST_DONE: begin
            cmd.publish = status.rsp_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

### rtl/gradient_magnitude_stream.sv
// ----------------------------------------------------------------------------
// gradient_magnitude_stream
// Central-difference gradient magnitude over a raster pixel stream.
// ----------------------------------------------------------------------------
// Pixels enter in raster order, one beat each; two line buffers hold the two
// rows above. Each interior pixel (row and column 1 .. size-2) yields one
// result beat with its row, column, floor(sqrt(dx^2 + dy^2)) and a last flag
// on the final interior pixel of the frame; its beat follows the pixel one
// row and one column past it. Border pixels produce nothing. Frame size comes
// from two registers (index 0 width, index 1 height), clamped to 3..1024 and
// 3..4096; any register write restarts the frame at row 0, column 0. Pixels
// are handled one at a time: a pixel that closes no interior window goes
// through idle and load; one that does also goes through square, the 9-step
// bit-serial square root and done, held there until the result register is
// free. A finished beat waits in it while the next pixel is accepted.
// ----------------------------------------------------------------------------
`include "gradient_magnitude_stream_defines.svh"

module gradient_magnitude_stream (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [gms_pkg::PixelBits-1:0]    req_pixel,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [gms_pkg::RowBits-1:0]      rsp_out_row,
   output logic [gms_pkg::ColBits-1:0]      rsp_out_col,
   output logic [gms_pkg::RootBits-1:0]     rsp_magnitude,
   output logic                             rsp_frame_last,
   input  logic                             csr_we,
   input  logic [gms_pkg::CsrIndexBits-1:0] csr_index,
   input  logic [gms_pkg::CsrDataBits-1:0]  csr_wdata
);
   import gms_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Sequencer: one pixel in flight, walks it through read, update and root.
   gms_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .status    (status)
   );

   // Storage and arithmetic: line buffers, window, counters, root unit.
   gms_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_pixel      (req_pixel),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .rsp_ready      (rsp_ready),
      .rsp_valid      (rsp_valid),
      .rsp_out_row    (rsp_out_row),
      .rsp_out_col    (rsp_out_col),
      .rsp_magnitude  (rsp_magnitude),
      .rsp_frame_last (rsp_frame_last)
   );

   // A captured pixel always moves on to the line-buffer update.
   `GMS_ASSERT_NEXT(a_capture_then_update, cmd.capture, cmd.update)
   // Only one pixel at a time: no accept right after an accept.
   `GMS_ASSERT_NEXT(a_single_item, req_valid && req_ready, !req_ready)
   // Never overwrite a beat that is still waiting.
   `GMS_ASSERT_SAME(a_publish_free, cmd.publish, !rsp_valid || rsp_ready)
   // Results only name interior pixels.
   `GMS_ASSERT_SAME(a_interior_only, rsp_valid, rsp_out_row != '0 && rsp_out_col != '0)

endmodule
